FILE: rtl/rsb_pkg.sv
package rsb_pkg;

   localparam int unsigned SOURCE_HEIGHT = 240;

   localparam int unsigned ADDR_W  = 22;
   localparam int unsigned COLOR_W = 16;
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned SW_W    = 11;
   localparam int unsigned OFS_W   = 10;
   localparam int unsigned ROW_W   = 11;   // row_offset + 2*column
   localparam int unsigned CSR_IDX_W = 2;

   // queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   // opcodes
   localparam logic OP_PALETTE_WRITE = 1'b0;
   localparam logic OP_DRAW_PIXEL    = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_OFFSET    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_OFFSET = 2'd2;

   localparam logic [SW_W-1:0]  SCREEN_WIDTH_RESET  = 11'd480;
   localparam logic [OFS_W-1:0] ROW_OFFSET_RESET    = 10'd144;
   localparam logic [OFS_W-1:0] COLUMN_OFFSET_RESET = 10'd0;

   typedef struct packed {
      logic       opcode;
      logic [7:0] color_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] source_column;
      logic [7:0] source_row;
   } req_item_type;

   // one pixel: first framebuffer address and the RGB565 color
   typedef struct packed {
      logic [ADDR_W-1:0]  address;
      logic [COLOR_W-1:0] color;
   } pixel_job_type;

   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
      logic                   not_empty;
   } queue_status_type;

endpackage

FILE: rtl/rsb_if.sv
interface rsb_req_if import rsb_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] color_index;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] source_column;
   logic [7:0] source_row;

   modport source (output valid, opcode, color_index, red, green, blue,
                   source_column, source_row, input ready);
   modport sink   (input valid, opcode, color_index, red, green, blue,
                   source_column, source_row, output ready);
endinterface

interface rsb_rsp_if import rsb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] write_address;
   logic [WORD_W-1:0] write_color;
   logic              last;

   modport source (output valid, write_address, write_color, last, input ready);
   modport sink   (input valid, write_address, write_color, last, output ready);
endinterface

FILE: rtl/rsb_front.sv
module rsb_front import rsb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  req_item_type        item,
   input  logic [SW_W-1:0]     screen_width,
   input  logic [OFS_W-1:0]    row_offset,
   input  logic [OFS_W-1:0]    column_offset,
   output logic                push_valid,
   output pixel_job_type       push_job,
   output logic [1:0]          inflight
);

   logic [COLOR_W-1:0] palette_mem [256];

   logic               s1_valid_ff, s1_valid_in;
   logic [ROW_W-1:0]   s1_row_ff, s1_row_in;
   logic [ADDR_W-1:0]  s1_ofs_ff, s1_ofs_in;
   logic [COLOR_W-1:0] s1_color_ff;
   logic               s2_valid_ff;
   pixel_job_type      s2_job_ff, s2_job_in;
   logic [COLOR_W-1:0] packed_color;
   logic [ADDR_W-1:0]  mirror_col;

   // RGB565 pack
   assign packed_color = {item.red[7:3], item.green[7:2], item.blue[7:3]};

   // 2*(H-1-row), wraps for rows beyond the image
   assign mirror_col = ADDR_W'(2 * (SOURCE_HEIGHT - 1))
                     - {{(ADDR_W-9){1'b0}}, item.source_row, 1'b0};

   always_comb begin
      s1_valid_in = accept && (item.opcode == OP_DRAW_PIXEL);
      s1_row_in   = ROW_W'(row_offset) + {{(ROW_W-9){1'b0}}, item.source_column, 1'b0};
      s1_ofs_in   = {{(ADDR_W-OFS_W){1'b0}}, column_offset} + mirror_col;
      s2_job_in.address = ADDR_W'({{(ADDR_W-ROW_W){1'b0}}, s1_row_ff}
                                  * {{(ADDR_W-SW_W){1'b0}}, screen_width}) + s1_ofs_ff;
      s2_job_in.color   = s1_color_ff;
   end

   always_ff @(posedge clock) begin
      if (accept && (item.opcode == OP_PALETTE_WRITE)) begin
         palette_mem[item.color_index] <= packed_color;
      end
      s1_color_ff <= palette_mem[item.color_index];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_row_ff <= s1_row_in;
      s1_ofs_ff <= s1_ofs_in;
      s2_job_ff <= s2_job_in;
   end

   assign push_valid = s2_valid_ff;
   assign push_job   = s2_job_ff;
   assign inflight   = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff};

endmodule

FILE: rtl/rsb_queue.sv
module rsb_queue import rsb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pixel_job_type    push_job,
   input  logic             pop,
   output pixel_job_type    head_job,
   output queue_status_type status
);

   pixel_job_type          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job         = entry_ff[rd_ptr_ff];
   assign status.count     = count_ff;
   assign status.not_empty = (count_ff != '0);

endmodule

FILE: rtl/rsb_back.sv
module rsb_back import rsb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [SW_W-1:0]  screen_width,
   input  logic             job_valid,
   input  pixel_job_type    job,
   output logic             pop,
   rsb_rsp_if.source        rsp
);

   logic               valid_ff, valid_in;
   logic               last_ff, last_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               xfer;

   assign xfer = valid_ff && rsp.ready;
   // take the next pixel when the output is empty or its second beat leaves
   assign pop  = job_valid && (!valid_ff || (xfer && last_ff));

   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      addr_in  = addr_ff;
      color_in = color_ff;
      priority if (pop) begin
         valid_in = 1'b1;
         last_in  = 1'b0;
         addr_in  = job.address;
         color_in = job.color;
      end else if (xfer && !last_ff) begin
         last_in = 1'b1;
         addr_in = addr_ff + {{(ADDR_W-SW_W){1'b0}}, screen_width};
      end else if (xfer) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      color_ff <= color_in;
   end

   assign rsp.valid         = valid_ff;
   assign rsp.write_address = addr_ff;
   assign rsp.write_color   = {color_ff, color_ff};
   assign rsp.last          = last_ff;

endmodule

FILE: rtl/rotate_scale2x_palette_blitter_unit.sv
// channel      dir  handshake               payload
// req_channel  in   valid/ready transfer    opcode, color_index, red, green, blue,
//                                           source_column, source_row
// rsp_channel  out  valid/ready transfer    write_address, write_color, last
// csr_*        in   csr_write_enable        csr_index, csr_write_data
//
// A palette write gives no transfer. A pixel gives two response beats (one
// transfer per beat) after passing front registers s1 and s2, the job queue and
// the output register. The single response port sets the pixel rate.
// Request transfers are accepted back to back while the pixels in the front pipe
// and the four-entry queue number fewer than four; response stalls can hold them.
// Reset (synchronous) empties the pipe and queue and loads the register defaults;
// the palette holds garbage until written.
module rotate_scale2x_palette_blitter_unit import rsb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rsb_req_if.sink               req_channel,
   rsb_rsp_if.source             rsp_channel,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SW_W-1:0]       csr_write_data
);

   logic [SW_W-1:0]  screen_width_ff;
   logic [OFS_W-1:0] row_offset_ff;
   logic [OFS_W-1:0] column_offset_ff;

   req_item_type     item;
   logic             accept;
   logic             push_valid;
   pixel_job_type    push_job;
   pixel_job_type    head_job;
   logic [1:0]       inflight;
   logic             pop;
   queue_status_type q_status;
   logic [QUEUE_CNT_W-1:0] committed;

   // config registers; the user must see they are only written while idle, not enforced here
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         row_offset_ff    <= ROW_OFFSET_RESET;
         column_offset_ff <= COLUMN_OFFSET_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_write_data;
            CSR_ROW_OFFSET:    row_offset_ff    <= csr_write_data[OFS_W-1:0];
            CSR_COLUMN_OFFSET: column_offset_ff <= csr_write_data[OFS_W-1:0];
            default: ;
         endcase
      end
   end

   assign item.opcode        = req_channel.opcode;
   assign item.color_index   = req_channel.color_index;
   assign item.red           = req_channel.red;
   assign item.green         = req_channel.green;
   assign item.blue          = req_channel.blue;
   assign item.source_column = req_channel.source_column;
   assign item.source_row    = req_channel.source_row;

   // every pixel in the front pipe has a queue slot reserved, so the pipe never stalls
   assign committed         = q_status.count + QUEUE_CNT_W'(inflight);
   assign req_channel.ready = (committed < QUEUE_CNT_W'(QUEUE_DEPTH));
   assign accept            = req_channel.valid && req_channel.ready;

   rsb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .item          (item),
      .screen_width  (screen_width_ff),
      .row_offset    (row_offset_ff),
      .column_offset (column_offset_ff),
      .push_valid    (push_valid),
      .push_job      (push_job),
      .inflight      (inflight)
   );

   rsb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   rsb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .screen_width (screen_width_ff),
      .job_valid    (q_status.not_empty),
      .job          (head_job),
      .pop          (pop),
      .rsp          (rsp_channel)
   );

endmodule

FILE: bench/rotate_scale2x_palette_blitter_unit_tb.sv
module rotate_scale2x_palette_blitter_unit_tb;
   import rsb_pkg::*;

   // Tracks the palette and the three registers, and holds the framebuffer
   // writes still owed by the block, oldest first.
   class blit_scoreboard;
      typedef struct packed {
         logic [ADDR_W-1:0] address;
         logic [WORD_W-1:0] color;
         logic              last;
      } fb_write_type;

      logic [COLOR_W-1:0] palette [256];
      logic [SW_W-1:0]    screen_width;
      logic [OFS_W-1:0]   row_offset;
      logic [OFS_W-1:0]   column_offset;
      fb_write_type       owed_writes [$];
      int unsigned        error_count;
      int unsigned        checked_count;
      int unsigned        palette_writes;
      int unsigned        pixel_draws;

      function new();
         screen_width   = SCREEN_WIDTH_RESET;
         row_offset     = ROW_OFFSET_RESET;
         column_offset  = COLUMN_OFFSET_RESET;
         error_count    = 0;
         checked_count  = 0;
         palette_writes = 0;
         pixel_draws    = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [SW_W-1:0] value);
         case (index)
            CSR_SCREEN_WIDTH:  screen_width  = value;
            CSR_ROW_OFFSET:    row_offset    = value[OFS_W-1:0];
            CSR_COLUMN_OFFSET: column_offset = value[OFS_W-1:0];
            default: ;
         endcase
      endfunction

      // Rotated 2x mapping: source column picks the screen row pair, source
      // row runs right to left across the screen. All math wraps at 32 bits
      // and the address keeps its low 22.
      function void note_request(req_item_type item);
         bit [31:0]          disp_row;
         bit [31:0]          disp_col;
         bit [31:0]          first_addr;
         bit [31:0]          second_addr;
         logic [COLOR_W-1:0] rgb565;
         fb_write_type       wr;
         if (item.opcode == OP_PALETTE_WRITE) begin
            palette[item.color_index] = {item.red[7:3], item.green[7:2], item.blue[7:3]};
            palette_writes++;
         end else begin
            pixel_draws++;
            rgb565      = palette[item.color_index];
            disp_row    = 32'(row_offset) + 32'(item.source_column) * 32'd2;
            disp_col    = (32'(SOURCE_HEIGHT) - 32'd1 - 32'(item.source_row)) * 32'd2;
            first_addr  = disp_row * 32'(screen_width) + 32'(column_offset) + disp_col;
            second_addr = first_addr + 32'(screen_width);
            wr.color    = {rgb565, rgb565};
            wr.address  = first_addr[ADDR_W-1:0];
            wr.last     = 1'b0;
            owed_writes.push_back(wr);
            wr.address  = second_addr[ADDR_W-1:0];
            wr.last     = 1'b1;
            owed_writes.push_back(wr);
         end
      endfunction

      function void check_write(logic [ADDR_W-1:0] address, logic [WORD_W-1:0] color,
                                logic last);
         fb_write_type exp_wr;
         if (owed_writes.size() == 0) begin
            $error("unexpected framebuffer write: address %0h color %0h last %0b",
                   address, color, last);
            error_count++;
         end else begin
            exp_wr = owed_writes.pop_front();
            checked_count++;
            if (address !== exp_wr.address) begin
               $error("write_address: expected %0h, got %0h", exp_wr.address, address);
               error_count++;
            end
            if (color !== exp_wr.color) begin
               $error("write_color: expected %0h, got %0h", exp_wr.color, color);
               error_count++;
            end
            if (last !== exp_wr.last) begin
               $error("last: expected %0b, got %0b", exp_wr.last, last);
               error_count++;
            end
         end
      endfunction
   endclass

   localparam int unsigned PHASES          = 6;
   localparam int unsigned ITEMS_PER_PHASE = 225;
   localparam int unsigned MAX_IDLE        = 10;
   // margin after the last owed write before the block counts as empty
   localparam int unsigned DRAIN_CYCLES    = 8;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SW_W-1:0]      csr_write_data;

   rsb_req_if req_channel ();
   rsb_rsp_if rsp_channel ();

   rotate_scale2x_palette_blitter_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_channel),
      .rsp_channel      (rsp_channel),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   blit_scoreboard sb = new();

   // palette slots written so far; draws only look up these
   bit          slot_written [256];
   logic [7:0]  written_slots [$];
   // idle stretches flip on and off so both busy and quiet runs occur
   bit          src_gaps_on = 1'b1;
   bit          snk_gaps_on = 1'b1;
   int unsigned settings_used = 1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: the slowest legal run is far below this.
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic req_item_type palette_item(logic [7:0] index, logic [7:0] r,
                                                 logic [7:0] g, logic [7:0] b);
      req_item_type item;
      item.opcode        = OP_PALETTE_WRITE;
      item.color_index   = index;
      item.red           = r;
      item.green         = g;
      item.blue          = b;
      // position is don't-care on a palette write, so scramble it
      item.source_column = 8'($urandom);
      item.source_row    = 8'($urandom);
      return item;
   endfunction

   function automatic req_item_type pixel_item(logic [7:0] index, logic [7:0] column,
                                               logic [7:0] row);
      req_item_type item;
      item.opcode        = OP_DRAW_PIXEL;
      item.color_index   = index;
      // color fields are don't-care on a draw
      item.red           = 8'($urandom);
      item.green         = 8'($urandom);
      item.blue          = 8'($urandom);
      item.source_column = column;
      item.source_row    = row;
      return item;
   endfunction

   // Mostly draws from written slots, about a third palette updates, and a
   // few rows past the bottom of the source image.
   function automatic req_item_type random_item();
      logic [7:0] row;
      if (written_slots.size() == 0 || $urandom_range(0, 9) < 3) begin
         return palette_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 9) == 0)
         row = 8'($urandom_range(SOURCE_HEIGHT, 255));
      else
         row = 8'($urandom_range(0, SOURCE_HEIGHT - 1));
      return pixel_item(written_slots[$urandom_range(0, written_slots.size() - 1)],
                        8'($urandom), row);
   endfunction

   // One request transfer: optional idle gap, then hold valid until ready.
   task automatic send_item(req_item_type item);
      int unsigned gap;
      gap = src_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (item.opcode == OP_PALETTE_WRITE && !slot_written[item.color_index]) begin
         slot_written[item.color_index] = 1'b1;
         written_slots.push_back(item.color_index);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_channel.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_channel.opcode        <= item.opcode;
      req_channel.color_index   <= item.color_index;
      req_channel.red           <= item.red;
      req_channel.green         <= item.green;
      req_channel.blue          <= item.blue;
      req_channel.source_column <= item.source_column;
      req_channel.source_row    <= item.source_row;
      req_channel.valid         <= 1'b1;
      @(posedge clock);
      while (!req_channel.ready) @(posedge clock);
      sb.note_request(item);
      if ($urandom_range(0, 63) == 0) src_gaps_on = !src_gaps_on;
   endtask

   // Drop valid and wait until every owed write has come out, then idle
   // for DRAIN_CYCLES more so the block is empty.
   task automatic drain();
      @(negedge clock);
      req_channel.valid <= 1'b0;
      while (sb.owed_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Only called with the block idle.
   task automatic program_registers(logic [SW_W-1:0] width, logic [OFS_W-1:0] rows,
                                    logic [OFS_W-1:0] cols);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SCREEN_WIDTH;
      csr_write_data   <= width;
      sb.set_register(CSR_SCREEN_WIDTH, width);
      @(negedge clock);
      csr_index        <= CSR_ROW_OFFSET;
      csr_write_data   <= SW_W'(rows);
      sb.set_register(CSR_ROW_OFFSET, SW_W'(rows));
      @(negedge clock);
      csr_index        <= CSR_COLUMN_OFFSET;
      csr_write_data   <= SW_W'(cols);
      sb.set_register(CSR_COLUMN_OFFSET, SW_W'(cols));
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   // Response side: random stall before each beat, sample at the rising edge.
   initial begin
      int unsigned stall;
      rsp_channel.ready = 1'b0;
      wait (!reset);
      forever begin
         stall = snk_gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_channel.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_channel.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_channel.valid) @(posedge clock);
         sb.check_write(rsp_channel.write_address, rsp_channel.write_color,
                        rsp_channel.last);
         if ($urandom_range(0, 63) == 0) snk_gaps_on = !snk_gaps_on;
      end
   end

   initial begin
      reset                     = 1'b1;
      csr_write_enable          = 1'b0;
      csr_index                 = CSR_SCREEN_WIDTH;
      csr_write_data            = '0;
      req_channel.valid         = 1'b0;
      req_channel.opcode        = OP_PALETTE_WRITE;
      req_channel.color_index   = '0;
      req_channel.red           = '0;
      req_channel.green         = '0;
      req_channel.blue          = '0;
      req_channel.source_column = '0;
      req_channel.source_row    = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: color extremes and alternating bit patterns, truncation of
      // the low color bits, corner positions, rows past the image bottom,
      // and a slot rewritten before it is drawn again. Reset registers.
      send_item(palette_item(8'h00, 8'h00, 8'h00, 8'h00));
      send_item(palette_item(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_item(palette_item(8'hAA, 8'hAA, 8'h55, 8'hAA));
      send_item(palette_item(8'h55, 8'h55, 8'hAA, 8'h55));
      send_item(palette_item(8'h07, 8'hF8, 8'hFC, 8'hF8));
      send_item(palette_item(8'h08, 8'h07, 8'h03, 8'h07));
      send_item(pixel_item(8'h00, 8'd0, 8'd0));
      send_item(pixel_item(8'hFF, 8'd255, 8'd239));
      send_item(pixel_item(8'hAA, 8'd0, 8'd239));
      send_item(pixel_item(8'h55, 8'd255, 8'd0));
      send_item(pixel_item(8'h07, 8'd128, 8'd120));
      send_item(pixel_item(8'h08, 8'd3, 8'd240));
      send_item(pixel_item(8'hFF, 8'd255, 8'd255));
      send_item(pixel_item(8'hAA, 8'd170, 8'd85));
      send_item(palette_item(8'h00, 8'h12, 8'h34, 8'h56));
      send_item(pixel_item(8'h00, 8'd1, 8'd1));
      send_item(pixel_item(8'h55, 8'd85, 8'd170));
      drain();

      // Random phases, each under its own register setting; phase 0 keeps
      // the reset values, then the minimum and maximum, then random ones.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 1)
            program_registers(SW_W'(2), OFS_W'(0), OFS_W'(0));
         else if (phase == 2)
            program_registers(SW_W'(1024), OFS_W'(1023), OFS_W'(1023));
         else if (phase > 2)
            program_registers(SW_W'($urandom_range(2, 1024)),
                              OFS_W'($urandom_range(0, 1023)),
                              OFS_W'($urandom_range(0, 1023)));
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_item(random_item());
         drain();
      end

      $display("Sent %0d palette writes and %0d pixel draws under %0d register settings.",
               sb.palette_writes, sb.pixel_draws, settings_used);
      $display("Checked %0d framebuffer writes, %0d still owed.",
               sb.checked_count, sb.owed_writes.size());
      if (sb.error_count == 0 && sb.owed_writes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
